// ----- src/annular_detector_hit_test_unit_assert.svh -----
// assertion macros for the annular detector hit test unit
`ifndef ANNULAR_DETECTOR_HIT_TEST_UNIT_ASSERT_SVH
`define ANNULAR_DETECTOR_HIT_TEST_UNIT_ASSERT_SVH
`ifndef SYNTH
`define ADH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ADH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ADH_ASSERT_IMPL(lbl, ante, cons, msg)
`define ADH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- src/adh_pkg.sv -----
// shared types, widths and codes of the annular detector hit test unit
package adh_pkg;

  localparam int DW      = 24;
  localparam int CW      = 16;
  localparam int PW      = DW + CW;
  localparam int DOTW    = PW + 2;
  localparam int DENW    = PW;
  localparam int SW      = 32;
  localparam int CSQW    = 2 * CW - 1;
  localparam int NUMW    = 58;
  localparam int QW      = 18;
  localparam int RW      = 20;
  localparam int ABSW    = 17;
  localparam int SQW     = 2 * ABSW;
  localparam int XW      = 36;
  localparam int SQRT_STEPS = XW / 2;
  localparam int LANES   = 3;

  localparam logic [1:0] ST_HIT   = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_INNER = 2'd2;
  localparam logic [1:0] ST_OUTER = 2'd3;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;
  localparam logic [2:0] REG_INNER    = 3'd3;
  localparam logic [2:0] REG_OUTER    = 3'd4;

  localparam logic signed [CW-1:0] RST_CENTER_X = 16'sd13;
  localparam logic signed [CW-1:0] RST_CENTER_Y = -16'sd128;
  localparam logic signed [CW-1:0] RST_CENTER_Z = 16'sd4416;
  localparam logic [CW-1:0]        RST_INNER    = 16'd738;
  localparam logic [CW-1:0]        RST_OUTER    = 16'd1984;

  typedef struct packed {
    logic signed [DW-1:0] dir_x;
    logic signed [DW-1:0] dir_y;
    logic signed [DW-1:0] dir_z;
    logic signed [CW-1:0] spot_x;
    logic signed [CW-1:0] spot_y;
    logic signed [CW-1:0] spot_z;
  } in_t;

  typedef struct packed {
    logic          hit;
    logic [1:0]    status;
    logic [CW-1:0] radial_distance;
  } out_t;

  typedef struct packed {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [CW-1:0] center_z;
    logic [CW-1:0]        inner_radius;
    logic [CW-1:0]        outer_radius;
  } cfg_t;

  // one item in the divider: three numerators share one denominator
  typedef struct packed {
    logic                       miss;
    logic                       ovf;
    logic [DENW-1:0]            den;
    logic [LANES-1:0]           neg;
    logic signed [CW-1:0]       spot_x;
    logic signed [CW-1:0]       spot_y;
    logic signed [CW-1:0]       spot_z;
    logic [LANES-1:0][NUMW-1:0] rem;
    logic [LANES-1:0][QW-1:0]   q;
  } div_st_t;

  typedef struct packed {
    logic           miss;
    logic           big;
    logic [SQW-1:0] sum;
    logic [XW-1:0]  x;
    logic [XW-1:0]  r;
  } sq_st_t;

endpackage

// ----- src/adh_front.sv -----
// front end: dot product, centre norm, scaled numerators and rounding offset
module adh_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  adh_pkg::in_t    in_data,
  input  adh_pkg::cfg_t   cfg,
  output logic            out_vld,
  output adh_pkg::div_st_t out_data
);
  import adh_pkg::*;

  logic signed [DW-1:0] dir [LANES];
  logic signed [CW-1:0] cen [LANES];

  // stage 1
  logic                 s1_vld_r;
  logic signed [PW-1:0] s1_prod_r [LANES];
  logic signed [PW-1:0] s1_prod_nxt [LANES];
  logic [CSQW-1:0]      s1_csq_r [LANES];
  logic [CSQW-1:0]      s1_csq_nxt [LANES];
  logic [DW-1:0]        s1_mag_r [LANES];
  logic [DW-1:0]        s1_mag_nxt [LANES];
  logic [LANES-1:0]     s1_neg_r;
  logic [LANES-1:0]     s1_neg_nxt;
  logic signed [CW-1:0] s1_spot_r [LANES];
  // stage 2
  logic                   s2_vld_r;
  logic signed [DOTW-1:0] s2_dot_r;
  logic signed [DOTW-1:0] s2_dot_nxt;
  logic [SW-1:0]          s2_s_r;
  logic [SW-1:0]          s2_s_nxt;
  logic [DW-1:0]          s2_mag_r [LANES];
  logic [LANES-1:0]       s2_neg_r;
  logic signed [CW-1:0]   s2_spot_r [LANES];
  // stage 3
  logic                 s3_vld_r;
  logic                 s3_miss_r;
  logic [DENW-1:0]      s3_den_r;
  logic [NUMW-1:0]      s3_num_r [LANES];
  logic [NUMW-1:0]      s3_num_nxt [LANES];
  logic [LANES-1:0]     s3_neg_r;
  logic signed [CW-1:0] s3_spot_r [LANES];
  // stage 4
  logic                 s4_vld_r;
  div_st_t              s4_r;
  div_st_t              s4_nxt;

  logic signed [2*CW-1:0] csq_full [LANES];
  logic [NUMW-1:0]        lim;
  logic                   ovf_any;

  always_comb begin
    dir[0] = in_data.dir_x;
    dir[1] = in_data.dir_y;
    dir[2] = in_data.dir_z;
    cen[0] = cfg.center_x;
    cen[1] = cfg.center_y;
    cen[2] = cfg.center_z;
    for (int i = 0; i < LANES; i++) begin
      s1_prod_nxt[i] = dir[i] * cen[i];
      csq_full[i]    = cen[i] * cen[i];
      s1_csq_nxt[i]  = csq_full[i][CSQW-1:0];
      s1_neg_nxt[i]  = dir[i][DW-1];
      s1_mag_nxt[i]  = s1_neg_nxt[i] ? DW'(-dir[i]) : DW'(dir[i]);
    end
  end

  always_comb begin
    s2_dot_nxt = DOTW'(s1_prod_r[0]) + DOTW'(s1_prod_r[1]) + DOTW'(s1_prod_r[2]);
    s2_s_nxt   = SW'(s1_csq_r[0]) + SW'(s1_csq_r[1]) + SW'(s1_csq_r[2]);
    for (int i = 0; i < LANES; i++) begin
      s3_num_nxt[i] = NUMW'(s2_mag_r[i]) * NUMW'(s2_s_r);
    end
  end

  // round to nearest: add half the denominator before the division
  always_comb begin
    lim = {s3_den_r, QW'(0)};
    ovf_any = 1'b0;
    s4_nxt.miss   = s3_miss_r;
    s4_nxt.den    = s3_den_r;
    s4_nxt.neg    = s3_neg_r;
    s4_nxt.spot_x = s3_spot_r[0];
    s4_nxt.spot_y = s3_spot_r[1];
    s4_nxt.spot_z = s3_spot_r[2];
    for (int i = 0; i < LANES; i++) begin
      s4_nxt.rem[i] = s3_num_r[i] + NUMW'(s3_den_r >> 1);
      s4_nxt.q[i]   = '0;
      if (s4_nxt.rem[i] >= lim) begin
        ovf_any = 1'b1;
      end
    end
    s4_nxt.ovf = ovf_any;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod_r    <= s1_prod_nxt;
      s1_csq_r     <= s1_csq_nxt;
      s1_mag_r     <= s1_mag_nxt;
      s1_neg_r     <= s1_neg_nxt;
      s1_spot_r[0] <= in_data.spot_x;
      s1_spot_r[1] <= in_data.spot_y;
      s1_spot_r[2] <= in_data.spot_z;
      s2_dot_r     <= s2_dot_nxt;
      s2_s_r       <= s2_s_nxt;
      s2_mag_r     <= s1_mag_r;
      s2_neg_r     <= s1_neg_r;
      s2_spot_r    <= s1_spot_r;
      s3_miss_r    <= s2_dot_r[DOTW-1] | (s2_dot_r == '0);
      s3_den_r     <= s2_dot_r[DENW-1:0];
      s3_num_r     <= s3_num_nxt;
      s3_neg_r     <= s2_neg_r;
      s3_spot_r    <= s2_spot_r;
      s4_r         <= s4_nxt;
    end
  end

  assign out_vld  = s4_vld_r;
  assign out_data = s4_r;

endmodule

// ----- src/adh_div.sv -----
// restoring divider, one quotient bit per stage on all three lanes
module adh_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  adh_pkg::div_st_t in_data,
  output logic             out_vld,
  output adh_pkg::div_st_t out_data
);
  import adh_pkg::*;

  logic    vld_r [QW];
  div_st_t stg_r [QW];
  div_st_t stg_nxt [QW];
  div_st_t src [QW];
  logic [NUMW-1:0] sub [QW][LANES];

  always_comb begin
    src[0] = in_data;
    for (int j = 1; j < QW; j++) begin
      src[j] = stg_r[j-1];
    end
    for (int j = 0; j < QW; j++) begin
      stg_nxt[j] = src[j];
      for (int i = 0; i < LANES; i++) begin
        sub[j][i] = NUMW'(src[j].den) << (QW - 1 - j);
        if (src[j].rem[i] >= sub[j][i]) begin
          stg_nxt[j].rem[i] = src[j].rem[i] - sub[j][i];
          stg_nxt[j].q[i][QW-1-j] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < QW; j++) begin
        vld_r[j] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int j = 1; j < QW; j++) begin
        vld_r[j] <= vld_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r <= stg_nxt;
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign out_data = stg_r[QW-1];

endmodule

// ----- src/adh_sqrt.sv -----
// integer square root, one result bit per stage
module adh_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  adh_pkg::sq_st_t in_data,
  output logic            out_vld,
  output adh_pkg::sq_st_t out_data
);
  import adh_pkg::*;

  logic   vld_r [SQRT_STEPS];
  sq_st_t stg_r [SQRT_STEPS];
  sq_st_t stg_nxt [SQRT_STEPS];
  sq_st_t src [SQRT_STEPS];
  logic [XW-1:0] bitv [SQRT_STEPS];
  logic [XW-1:0] trial [SQRT_STEPS];

  always_comb begin
    src[0] = in_data;
    for (int j = 1; j < SQRT_STEPS; j++) begin
      src[j] = stg_r[j-1];
    end
    for (int j = 0; j < SQRT_STEPS; j++) begin
      bitv[j]    = XW'(1) << (2 * (SQRT_STEPS - 1 - j));
      trial[j]   = src[j].r + bitv[j];
      stg_nxt[j] = src[j];
      if (src[j].x >= trial[j]) begin
        stg_nxt[j].x = src[j].x - trial[j];
        stg_nxt[j].r = (src[j].r >> 1) + bitv[j];
      end else begin
        stg_nxt[j].r = src[j].r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < SQRT_STEPS; j++) begin
        vld_r[j] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int j = 1; j < SQRT_STEPS; j++) begin
        vld_r[j] <= vld_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r <= stg_nxt;
    end
  end

  assign out_vld  = vld_r[SQRT_STEPS-1];
  assign out_data = stg_r[SQRT_STEPS-1];

endmodule

// ----- src/annular_detector_hit_test_unit.sv -----
// path: front end, divider, residual, square and sum stages, square root, output register
// throughput: one transaction per cycle; the whole pipeline advances when the output
// register is empty or being taken, so a stall at out_ready holds every stage
// the 18-stage divider and 18-stage square root set the latency
// reset: synchronous active-low rst_n clears all valid bits and loads register defaults
module annular_detector_hit_test_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  adh_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output adh_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import adh_pkg::*;

  logic    en;
  cfg_t    cfg_r;
  logic [2*CW-1:0] rin_sq_r;
  logic [2*CW-1:0] rout_sq_r;

  logic    fe_vld;
  div_st_t fe_data;
  logic    dv_vld;
  div_st_t dv_data;

  // residual stage
  logic                 rs_vld_r;
  logic                 rs_miss_r;
  logic                 rs_big_r;
  logic signed [RW-1:0] rs_r_r [LANES];
  logic signed [RW-1:0] rs_r_nxt [LANES];
  logic                 rs_big_nxt;
  logic signed [CW-1:0] spot [LANES];
  logic signed [CW-1:0] cen [LANES];
  logic signed [RW-1:0] qs [LANES];
  // square stage
  logic            sq_vld_r;
  logic            sq_miss_r;
  logic            sq_big_r;
  logic [SQW-1:0]  sq_r [LANES];
  logic [SQW-1:0]  sq_nxt [LANES];
  logic [ABSW-1:0] rabs [LANES];
  logic [RW-1:0]   rabs_full [LANES];
  // sum stage
  logic           sm_vld_r;
  sq_st_t         sm_r;
  sq_st_t         sm_nxt;
  logic           rt_vld;
  sq_st_t         rt_data;
  logic           out_valid_r;
  out_t           out_r;
  out_t           out_nxt;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x     <= RST_CENTER_X;
      cfg_r.center_y     <= RST_CENTER_Y;
      cfg_r.center_z     <= RST_CENTER_Z;
      cfg_r.inner_radius <= RST_INNER;
      cfg_r.outer_radius <= RST_OUTER;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_CENTER_X: cfg_r.center_x     <= pwdata[CW-1:0];
        REG_CENTER_Y: cfg_r.center_y     <= pwdata[CW-1:0];
        REG_CENTER_Z: cfg_r.center_z     <= pwdata[CW-1:0];
        REG_INNER:    cfg_r.inner_radius <= pwdata[CW-1:0];
        REG_OUTER:    cfg_r.outer_radius <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_CENTER_X: prdata = 32'({cfg_r.center_x});
      REG_CENTER_Y: prdata = 32'({cfg_r.center_y});
      REG_CENTER_Z: prdata = 32'({cfg_r.center_z});
      REG_INNER:    prdata = 32'(cfg_r.inner_radius);
      REG_OUTER:    prdata = 32'(cfg_r.outer_radius);
      default:      prdata = '0;
    endcase
  end

  // squared radii follow registers the user must change only while idle; unenforced
  always_ff @(posedge clk) begin
    rin_sq_r  <= cfg_r.inner_radius * cfg_r.inner_radius;
    rout_sq_r <= cfg_r.outer_radius * cfg_r.outer_radius;
  end

  adh_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .out_vld  (fe_vld),
    .out_data (fe_data)
  );

  adh_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (fe_vld),
    .in_data  (fe_data),
    .out_vld  (dv_vld),
    .out_data (dv_data)
  );

  // r = signed quotient + spot - centre
  always_comb begin
    spot[0] = dv_data.spot_x;
    spot[1] = dv_data.spot_y;
    spot[2] = dv_data.spot_z;
    cen[0]  = cfg_r.center_x;
    cen[1]  = cfg_r.center_y;
    cen[2]  = cfg_r.center_z;
    rs_big_nxt = dv_data.ovf;
    for (int i = 0; i < LANES; i++) begin
      qs[i] = dv_data.neg[i] ? -RW'(dv_data.q[i]) : RW'(dv_data.q[i]);
      rs_r_nxt[i] = qs[i] + RW'(spot[i]) - RW'(cen[i]);
      if (rs_r_nxt[i] > RW'(65535) || rs_r_nxt[i] < -RW'(65535)) begin
        rs_big_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rabs_full[i] = rs_r_r[i][RW-1] ? RW'(-rs_r_r[i]) : RW'(rs_r_r[i]);
      rabs[i]      = rabs_full[i][ABSW-1:0];
      sq_nxt[i]    = SQW'(rabs[i]) * SQW'(rabs[i]);
    end
    sm_nxt.miss = sq_miss_r;
    sm_nxt.big  = sq_big_r;
    sm_nxt.sum  = sq_r[0] + sq_r[1] + sq_r[2];
    sm_nxt.x    = XW'(sm_nxt.sum);
    sm_nxt.r    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_vld_r <= 1'b0;
      sq_vld_r <= 1'b0;
      sm_vld_r <= 1'b0;
    end else if (en) begin
      rs_vld_r <= dv_vld;
      sq_vld_r <= rs_vld_r;
      sm_vld_r <= sq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs_miss_r <= dv_data.miss;
      rs_big_r  <= rs_big_nxt;
      rs_r_r    <= rs_r_nxt;
      sq_miss_r <= rs_miss_r;
      sq_big_r  <= rs_big_r;
      sq_r      <= sq_nxt;
      sm_r      <= sm_nxt;
    end
  end

  adh_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (sm_vld_r),
    .in_data  (sm_r),
    .out_vld  (rt_vld),
    .out_data (rt_data)
  );

  always_comb begin
    out_nxt.radial_distance = (rt_data.r > XW'(65535)) ? 16'hFFFF : rt_data.r[CW-1:0];
    if (rt_data.miss) begin
      out_nxt.hit             = 1'b0;
      out_nxt.status          = ST_MISS;
      out_nxt.radial_distance = '0;
    end else if (rt_data.big) begin
      out_nxt.hit             = 1'b0;
      out_nxt.status          = ST_OUTER;
      out_nxt.radial_distance = 16'hFFFF;
    end else if (rt_data.sum < SQW'(rin_sq_r)) begin
      out_nxt.hit    = 1'b0;
      out_nxt.status = ST_INNER;
    end else if (rt_data.sum > SQW'(rout_sq_r)) begin
      out_nxt.hit    = 1'b0;
      out_nxt.status = ST_OUTER;
    end else begin
      out_nxt.hit    = 1'b1;
      out_nxt.status = ST_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= rt_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`include "annular_detector_hit_test_unit_assert.svh"

  `ADH_ASSERT_IMPL(a_hit_status, out_valid, out_data.hit == (out_data.status == ST_HIT), "hit and status disagree")
  `ADH_ASSERT_IMPL(a_hit_in_gate, out_valid && out_data.hit, out_data.radial_distance >= cfg_r.inner_radius && out_data.radial_distance <= cfg_r.outer_radius, "hit outside annulus")
  `ADH_ASSERT_IMPL(a_miss_zero, out_valid && out_data.status == ST_MISS, out_data.radial_distance == '0, "miss with nonzero distance")
  `ADH_ASSERT_NEXT(a_sqrt_to_out, rt_vld && en, out_valid, "finished item not presented")

endmodule

// ----- tb/sv/tb_annular_detector_hit_test_unit.sv -----
// self-checking testbench for the annular detector hit test unit
module tb_annular_detector_hit_test_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import adh_pkg::*;

  localparam int LATENCY    = 44;
  localparam int IDLE_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  annular_detector_hit_test_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // local copy of the detector geometry
  cfg_t geom;
  out_t pending_hits[$];
  int   mismatches;
  int   results_seen;
  int   hits_seen;
  int   misses_seen;
  int   items_sent;
  int   idle_cycles;
  bit   busy_mode;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic out_t predict_hit(in_t it);
    longint d[3];
    longint b[3];
    longint c[3];
    longint r[3];
    longint dot;
    longint s;
    longint mag;
    longint q;
    longint unsigned sum;
    longint unsigned root;
    longint unsigned rin;
    longint unsigned rout;
    bit big;
    out_t o;
    d[0] = it.dir_x;
    d[1] = it.dir_y;
    d[2] = it.dir_z;
    b[0] = it.spot_x;
    b[1] = it.spot_y;
    b[2] = it.spot_z;
    c[0] = geom.center_x;
    c[1] = geom.center_y;
    c[2] = geom.center_z;
    rin = geom.inner_radius;
    rout = geom.outer_radius;
    dot = 0;
    s = 0;
    big = 1'b0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      dot += d[i] * c[i];
      s += c[i] * c[i];
    end
    if (dot <= 0) begin
      o.hit = 1'b0;
      o.status = ST_MISS;
      o.radial_distance = '0;
      return o;
    end
    for (int i = 0; i < 3; i++) begin
      // intersection point rounded half away from zero
      mag = (d[i] < 0) ? -d[i] : d[i];
      q = (mag * s + dot / 2) / dot;
      r[i] = ((d[i] < 0) ? -q : q) + b[i] - c[i];
      if (r[i] > 65535 || r[i] < -65535) big = 1'b1;
    end
    if (big) begin
      o.hit = 1'b0;
      o.status = ST_OUTER;
      o.radial_distance = 16'hffff;
      return o;
    end
    for (int i = 0; i < 3; i++) sum += r[i] * r[i];
    root = int_sqrt(sum);
    o.radial_distance = (root > 65535) ? 16'hffff : root[15:0];
    if (sum < rin * rin) begin
      o.hit = 1'b0;
      o.status = ST_INNER;
    end else if (sum > rout * rout) begin
      o.hit = 1'b0;
      o.status = ST_OUTER;
    end else begin
      o.hit = 1'b1;
      o.status = ST_HIT;
    end
    return o;
  endfunction

  function automatic int pick_gap();
    int p;
    if (busy_mode) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // predict on every accepted input transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) pending_hits.push_back(predict_hit(in_data));
  end

  // compare every accepted result against the oldest prediction
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_data.hit) hits_seen++;
      if (out_data.status == ST_MISS) misses_seen++;
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = pending_hits.pop_front();
        if (out_data.hit !== want.hit || out_data.status !== want.status ||
            out_data.radial_distance !== want.radial_distance) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected hit=%0b status=%0d dist=%0d, got hit=%0b status=%0d dist=%0d",
                     results_seen, want.hit, want.status, want.radial_distance,
                     out_data.hit, out_data.status, out_data.radial_distance);
        end
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    int stall;
    if (!rst_n) begin
      out_ready = 1'b0;
    end else if (stall > 0) begin
      stall--;
      out_ready = 1'b0;
    end else begin
      stall = pick_gap();
      out_ready = (stall == 0);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_item(in_t it);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = {16'h0, val};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_CENTER_X: geom.center_x = val;
      REG_CENTER_Y: geom.center_y = val;
      REG_CENTER_Z: geom.center_z = val;
      REG_INNER:    geom.inner_radius = val;
      default:      geom.outer_radius = val;
    endcase
  endtask

  task automatic set_geometry(logic [15:0] cx, logic [15:0] cy, logic [15:0] cz,
                              logic [15:0] rin, logic [15:0] rout);
    drain();
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_INNER, rin);
    write_reg(REG_OUTER, rout);
  endtask

  function automatic logic [23:0] clamp24(longint v);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  // direction roughly along the centre so the ray lands near the annulus
  function automatic in_t aimed_item();
    in_t it;
    longint k;
    longint spread;
    k = $urandom_range(1, 255);
    spread = k * $urandom_range(0, 64);
    it.dir_x = clamp24(k * geom.center_x + $signed($urandom_range(0, 32'(2 * spread))) - spread);
    it.dir_y = clamp24(k * geom.center_y + $signed($urandom_range(0, 32'(2 * spread))) - spread);
    it.dir_z = clamp24(k * geom.center_z + $signed($urandom_range(0, 32'(2 * spread))) - spread);
    if ($urandom_range(0, 9) == 0) begin
      it.spot_x = 16'($urandom);
      it.spot_y = 16'($urandom);
      it.spot_z = 16'($urandom);
    end else begin
      it.spot_x = 16'($signed($urandom_range(0, 4096)) - 2048);
      it.spot_y = 16'($signed($urandom_range(0, 4096)) - 2048);
      it.spot_z = 16'($signed($urandom_range(0, 512)) - 256);
    end
    return it;
  endfunction

  function automatic in_t noise_item();
    in_t it;
    it.dir_x = 24'($urandom);
    it.dir_y = 24'($urandom);
    it.dir_z = 24'($urandom);
    it.spot_x = 16'($urandom);
    it.spot_y = 16'($urandom);
    it.spot_z = 16'($urandom);
    return it;
  endfunction

  task automatic run_random(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) busy_mode = ($urandom_range(0, 3) == 0);
      send_item(($urandom_range(0, 3) == 0) ? noise_item() : aimed_item());
    end
    busy_mode = 1'b0;
  endtask

  task automatic test_reset_geometry();
    in_t it;
    // zero direction misses the plane
    it = '0;
    send_item(it);
    // straight at the centre, no offset lands inside the inner radius
    it.dir_x = 24'(RST_CENTER_X);
    it.dir_y = 24'(RST_CENTER_Y);
    it.dir_z = 24'(RST_CENTER_Z);
    send_item(it);
    // offset into the annulus
    it.spot_x = 16'sd1000;
    send_item(it);
    // exactly on inner and outer edges
    it.spot_x = 16'sd0;
    it.spot_y = RST_INNER;
    send_item(it);
    it.spot_y = RST_OUTER;
    send_item(it);
    it.spot_y = 16'(RST_OUTER + 1);
    send_item(it);
    // pointing away
    it = '0;
    it.dir_z = -24'sd5;
    send_item(it);
    it.dir_x = 24'sh7fffff;
    it.dir_y = 24'sh7fffff;
    it.dir_z = 24'sh7fffff;
    it.spot_x = 16'sh7fff;
    it.spot_y = 16'sh8000;
    it.spot_z = 16'sh7fff;
    send_item(it);
    it.dir_x = 24'sh800000;
    it.dir_y = 24'sh800000;
    it.dir_z = 24'sh7fffff;
    it.spot_x = 16'sh8000;
    it.spot_y = 16'sh7fff;
    it.spot_z = 16'sh8000;
    send_item(it);
    // grazing ray gives a huge intersection point
    it = '0;
    it.dir_x = 24'sh7fffff;
    it.dir_z = 24'sd1;
    send_item(it);
    run_random(200);
  endtask

  task automatic test_geometry_extremes();
    in_t it;
    // zero centre: every ray misses
    set_geometry(16'h0, 16'h0, 16'h0, 16'd738, 16'd1984);
    it = noise_item();
    send_item(it);
    it = '0;
    it.dir_z = 24'sd100;
    send_item(it);
    // largest centre components, widest gate
    set_geometry(16'h8000, 16'h8000, 16'h7fff, 16'd0, 16'hffff);
    it = '0;
    it.dir_x = -24'sd32768;
    it.dir_y = -24'sd32768;
    it.dir_z = 24'sd32767;
    send_item(it);
    it.spot_x = 16'sh7fff;
    it.spot_y = 16'sh7fff;
    it.spot_z = 16'sh8000;
    send_item(it);
    run_random(250);
    // inner edge above outer edge
    set_geometry(16'd0, 16'd0, 16'd4096, 16'd3000, 16'd1000);
    it = '0;
    it.dir_z = 24'sd1;
    it.spot_x = 16'sd2000;
    send_item(it);
    it.spot_x = 16'sd3500;
    send_item(it);
    run_random(250);
    // closed gate
    set_geometry(16'd200, 16'd300, 16'd2000, 16'd0, 16'd0);
    run_random(200);
  endtask

  task automatic test_random_geometries();
    for (int p = 0; p < 4; p++) begin
      set_geometry(16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom_range(0, 4000)), 16'($urandom_range(500, 65535)));
      run_random(200);
    end
    set_geometry(RST_CENTER_X, RST_CENTER_Y, RST_CENTER_Z, RST_INNER, RST_OUTER);
    run_random(300);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    busy_mode = 1'b0;
    geom.center_x = RST_CENTER_X;
    geom.center_y = RST_CENTER_Y;
    geom.center_z = RST_CENTER_Z;
    geom.inner_radius = RST_INNER;
    geom.outer_radius = RST_OUTER;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    test_reset_geometry();
    test_geometry_extremes();
    test_random_geometries();
    drain();
    $display("sent %0d events over 9 detector geometries, checked %0d results", items_sent,
             results_seen);
    $display("%0d hits, %0d plane misses, %0d mismatches, %0d still pending", hits_seen,
             misses_seen, mismatches, pending_hits.size());
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
